// File: hw/rtl/wgd_pkg.sv
// Shared constants for the wavecycle group deleter.
package wgd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int LEVEL_W    = 28;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_POS = 2'd2;

    localparam logic [1:0] MODE_KEEP_FIRST = 2'd0;
    localparam logic [1:0] MODE_LOUDEST    = 2'd1;
    localparam logic [1:0] MODE_QUIETEST   = 2'd2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

endpackage

// File: hw/rtl/wgd_req_if.sv
// Request channel: push or pull transactions.
interface wgd_req_if
    import wgd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_stream;

    modport source (output valid, req_type, sample, end_of_stream, input ready);
    modport sink   (input valid, req_type, sample, end_of_stream, output ready);
endinterface

// File: hw/rtl/wgd_res_if.sv
// Result channel: one transaction per accepted request.
interface wgd_res_if
    import wgd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          out_valid;
    logic                          out_last;
    logic                          overflow;

    modport source (output valid, out_sample, out_valid, out_last, overflow, input ready);
    modport sink   (input valid, out_sample, out_valid, out_last, overflow, output ready);
endinterface

// File: hw/rtl/wgd_cfg_if.sv
// Configuration write channel.
interface wgd_cfg_if
    import wgd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/wgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wgd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: hw/rtl/wavecycle_group_deleter.sv
// Wavecycle group deleter top level: cycle tracking, sample ring and range queue.
// Takes one request transaction per clock while req.ready is high, push or pull, and returns one result
// transaction for each, in the cycle after acceptance, through a result register. A new
// request is taken whenever that register is empty or its result is taken in the same
// cycle, so requests can follow back to back. Cycle tracking, best-cycle choice and
// range queueing complete in the acceptance cycle. The start of each cycle of the
// group is kept in a small register table. A pull reads the ring RAM in the
// acceptance cycle, and the registered read data feeds the result. No clearing pass
// is needed.
module wavecycle_group_deleter
    import wgd_pkg::*;
#(
    parameter int STORE_DEPTH = 4096,
    parameter int GROUP_MAX   = 16,
    parameter int RANGE_SLOTS = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    wgd_req_if.sink   req,
    wgd_res_if.source res,
    wgd_cfg_if.sink   cfg
);
    localparam int PW  = $clog2(STORE_DEPTH);
    localparam int CW  = $clog2(GROUP_MAX + 2);
    localparam int SW  = $clog2(GROUP_MAX + 1);
    localparam int QCW = $clog2(RANGE_SLOTS + 1);
    localparam int QIW = $clog2(RANGE_SLOTS);

    typedef struct packed {
        logic [RANGE_SLOTS-1:0][PW-1:0] qs;
        logic [RANGE_SLOTS-1:0][PW-1:0] qe;
        logic [QCW-1:0]                 cnt;
        logic [PW-1:0]                  rp;
        logic                           ov;
    } queue_t;

    typedef logic [GROUP_MAX:0][PW-1:0] starts_t;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(STORE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // group indexes beyond the table saturate at its last entry
    function automatic logic [PW-1:0] st_at(input starts_t st, input logic [CW-1:0] i);
        logic [PW-1:0] r;
        if (int'(i) > GROUP_MAX)
        begin
            r = st[GROUP_MAX];
        end
        else
        begin
            r = st[SW'(i)];
        end
        return r;
    endfunction

    function automatic starts_t st_set(input starts_t st, input logic [CW-1:0] i,
                                       input logic [PW-1:0] v);
        starts_t r;
        r = st;
        if (int'(i) <= GROUP_MAX)
        begin
            r[SW'(i)] = v;
        end
        return r;
    endfunction

    function automatic queue_t enq(input queue_t q, input logic [PW-1:0] s,
                                   input logic [PW-1:0] e);
        queue_t r;
        r = q;
        if (s != e)
        begin
            if (int'(q.cnt) >= RANGE_SLOTS)
            begin
                r.ov = 1'b1;
            end
            else
            begin
                r.qs[q.cnt[QIW-1:0]] = s;
                r.qe[q.cnt[QIW-1:0]] = e;
                if (q.cnt == '0)
                begin
                    r.rp = s;
                end
                r.cnt = q.cnt + 1'b1;
            end
        end
        return r;
    endfunction

    function automatic queue_t close_grp(input queue_t q, input starts_t st,
                                         input logic [1:0] m, input logic [CW-1:0] b,
                                         input logic [CW-1:0] done);
        queue_t r;
        if (m == MODE_LOUDEST)
        begin
            r = enq(q, st_at(st, b), st_at(st, b + 1'b1));
        end
        else
        begin
            r = enq(q, st_at(st, '0), st_at(st, b));
            r = enq(r, st_at(st, b + 1'b1), st_at(st, done));
        end
        return r;
    endfunction

    logic [1:0]            mode_reg;
    logic [CFG_DATA_W-1:0] grp_reg;
    logic                  start_pos_reg;

    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] blevel_reg, blevel_next;
    logic [CW-1:0]      bcyc_reg, bcyc_next;
    logic [CW-1:0]      cig_reg, cig_next;
    logic               half_reg, half_next;
    logic [PW-1:0]      wp_reg, wp_next;
    starts_t            st_reg, st_next;
    logic               ended_reg, ended_next;
    queue_t             q_reg, q_next;

    logic                   res_vld_reg;
    logic                   res_rd_reg, res_rd_next;
    logic                   res_last_reg, res_last_next;
    logic                   res_ov_reg, res_ov_next;

    logic                   acc;
    logic                   ram_we;
    logic                   ram_re;
    logic [PW-1:0]          ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    assign req.ready = !res_vld_reg || res.ready;
    assign acc       = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign res.valid      = res_vld_reg;
    assign res.out_sample = res_rd_reg ? ram_rdata : '0;
    assign res.out_valid  = res_rd_reg;
    assign res.out_last   = res_last_reg;
    assign res.overflow   = res_ov_reg;

    wgd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (req.sample),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic [1:0]           m;
        logic [CW-1:0]        n;
        logic                 neg;
        logic                 zero;
        logic                 first_ok;
        logic                 second_ok;
        logic                 upd;
        logic [SAMPLE_BITS-1:0] mag;
        logic [LEVEL_W:0]     sum;
        logic [PW-1:0]        oldest;
        logic [PW:0]          used;
        logic                 full;
        int                   gsat;

        level_next    = level_reg;
        blevel_next   = blevel_reg;
        bcyc_next     = bcyc_reg;
        cig_next      = cig_reg;
        half_next     = half_reg;
        wp_next       = wp_reg;
        st_next       = st_reg;
        ended_next    = ended_reg;
        q_next        = q_reg;
        q_next.ov     = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = q_reg.rp;
        res_rd_next   = 1'b0;
        res_last_next = 1'b0;
        full          = 1'b0;

        case (mode_reg)
            MODE_KEEP_FIRST: m = MODE_KEEP_FIRST;
            MODE_QUIETEST:   m = MODE_QUIETEST;
            default:         m = MODE_LOUDEST;
        endcase
        gsat = (int'(grp_reg) > GROUP_MAX) ? GROUP_MAX : int'(grp_reg);
        if (m != MODE_KEEP_FIRST && gsat == 0)
        begin
            gsat = 1;
        end
        n = CW'(gsat);

        neg       = req.sample[SAMPLE_BITS-1];
        zero      = (req.sample == '0);
        first_ok  = start_pos_reg ? !neg : (neg || zero);
        second_ok = start_pos_reg ? (neg || zero) : !neg;
        mag       = neg ? (~req.sample + 1'b1) : req.sample;
        oldest    = '0;
        used      = '0;
        upd       = 1'b0;
        sum       = '0;

        if (acc && req.req_type == REQ_PUSH && !ended_reg)
        begin
            if (half_reg && !second_ok)
            begin
                if (m == MODE_KEEP_FIRST)
                begin
                    if (cig_next == '0)
                    begin
                        q_next = enq(q_next, st_at(st_next, '0), wp_next);
                    end
                    cig_next = cig_next + 1'b1;
                    if ({1'b0, cig_next} >= {1'b0, n} + 1'b1)
                    begin
                        cig_next    = '0;
                        blevel_next = '0;
                        bcyc_next   = '0;
                        st_next     = st_set(st_next, '0, wp_next);
                    end
                end
                else
                begin
                    if (m == MODE_LOUDEST)
                    begin
                        upd = level_next > blevel_next;
                    end
                    else
                    begin
                        upd = (cig_next == '0) || (level_next < blevel_next);
                    end
                    if (upd)
                    begin
                        blevel_next = level_next;
                        bcyc_next   = cig_next;
                    end
                    st_next  = st_set(st_next, cig_next + 1'b1, wp_next);
                    cig_next = cig_next + 1'b1;
                    if (cig_next >= n)
                    begin
                        st_next     = st_set(st_next, cig_next, wp_next);
                        q_next      = close_grp(q_next, st_next, m, bcyc_next, cig_next);
                        cig_next    = '0;
                        blevel_next = '0;
                        bcyc_next   = '0;
                        st_next     = st_set(st_next, '0, wp_next);
                    end
                end
                level_next  = '0;
                half_next   = 1'b0;
            end
            else if (!half_reg && !first_ok)
            begin
                half_next = 1'b1;
            end

            sum = {1'b0, level_next} + (LEVEL_W + 1)'(mag);
            level_next = (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[LEVEL_W-1:0];

            if (m != MODE_KEEP_FIRST || cig_next == '0)
            begin
                oldest = (q_next.cnt != '0) ? q_next.rp : st_at(st_next, '0);
                used   = (wp_next >= oldest) ? {1'b0, wp_next - oldest}
                       : ({1'b0, wp_next} + (PW + 1)'(STORE_DEPTH) - {1'b0, oldest});
                if (used >= (PW + 1)'(STORE_DEPTH - 1))
                begin
                    full = 1'b1;
                end
                else
                begin
                    ram_we  = 1'b1;
                    wp_next = ring_next(wp_next);
                end
            end

            if (req.end_of_stream)
            begin
                if (m == MODE_KEEP_FIRST)
                begin
                    if (cig_next == '0)
                    begin
                        q_next = enq(q_next, st_at(st_next, '0), wp_next);
                    end
                end
                else if (cig_next != '0)
                begin
                    st_next = st_set(st_next, cig_next, wp_next);
                    q_next  = close_grp(q_next, st_next, m, bcyc_next, cig_next);
                end
                ended_next = 1'b1;
            end
        end
        else if (acc && req.req_type == REQ_PULL && q_reg.cnt != '0)
        begin
            ram_re      = 1'b1;
            res_rd_next = 1'b1;
            q_next.rp   = ring_next(q_reg.rp);
            if (q_next.rp == q_reg.qe[0])
            begin
                for (int k = 1; k < RANGE_SLOTS; k++)
                begin
                    q_next.qs[k-1] = q_reg.qs[k];
                    q_next.qe[k-1] = q_reg.qe[k];
                end
                q_next.cnt = q_reg.cnt - 1'b1;
                if (q_next.cnt != '0)
                begin
                    q_next.rp = q_reg.qs[1];
                end
            end
            res_last_next = ended_reg && (q_next.cnt == '0);
        end

        res_ov_next = q_next.ov || full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_LOUDEST;
            grp_reg       <= CFG_DATA_W'(2);
            start_pos_reg <= 1'b1;
            level_reg     <= '0;
            blevel_reg    <= '0;
            bcyc_reg      <= '0;
            cig_reg       <= '0;
            half_reg      <= 1'b0;
            wp_reg        <= '0;
            st_reg        <= '0;
            ended_reg     <= 1'b0;
            q_reg         <= '0;
            res_vld_reg   <= 1'b0;
            res_rd_reg    <= 1'b0;
            res_last_reg  <= 1'b0;
            res_ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_MODE:      mode_reg      <= cfg.data[1:0];
                    REG_GROUP:     grp_reg       <= cfg.data;
                    REG_START_POS: start_pos_reg <= cfg.data[0];
                    default:       ;
                endcase
            end
            if (acc)
            begin
                level_reg    <= level_next;
                blevel_reg   <= blevel_next;
                bcyc_reg     <= bcyc_next;
                cig_reg      <= cig_next;
                half_reg     <= half_next;
                wp_reg       <= wp_next;
                st_reg       <= st_next;
                ended_reg    <= ended_next;
                q_reg        <= q_next;
                res_rd_reg   <= res_rd_next;
                res_last_reg <= res_last_next;
                res_ov_reg   <= res_ov_next;
            end
            if (acc)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end
endmodule

// File: bench/wavecycle_group_deleter_test.sv
// Testbench for the wavecycle group deleter: directed and random push/pull traffic, checked by a local predictor.
module wavecycle_group_deleter_test;
    import wgd_pkg::*;

    localparam int DEPTH     = 4096;
    localparam int GMAX      = 16;
    localparam int SLOTS     = 4;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic [15:0] smp;
        logic        vld;
        logic        lst;
        logic        ovf;
    } pull_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    wgd_req_if #(.SAMPLE_BITS(16)) req_bus ();
    wgd_res_if #(.SAMPLE_BITS(16)) res_bus ();
    wgd_cfg_if cfg_bus ();

    wavecycle_group_deleter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    always #2 clk = ~clk;

    // predictor state
    logic [15:0] ring [DEPTH];
    int unsigned starts [GMAX+1];
    int unsigned span_lo [SLOTS];
    int unsigned span_hi [SLOTS];
    int unsigned level, best_level, best_idx, grp_pos, second_half;
    int unsigned wp, rp, span_n, ended;
    int unsigned cur_mode, cur_group, cur_startpos;

    pull_result_t expected_results [$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // wave shaping state for stimulus
    int half_left = 0;
    bit half_neg = 0;

    function automatic int unsigned start_at(int unsigned i);
        if (i > GMAX) i = GMAX;
        return starts[i] % DEPTH;
    endfunction

    function automatic void set_start(int unsigned i, int unsigned v);
        if (i <= GMAX) starts[i] = v;
    endfunction

    function automatic bit add_span(int unsigned s, int unsigned e);
        if (s == e) return 1'b0;
        if (span_n >= SLOTS) return 1'b1;
        span_lo[span_n] = s;
        span_hi[span_n] = e;
        if (span_n == 0) rp = s;
        span_n++;
        return 1'b0;
    endfunction

    function automatic int unsigned eff_mode();
        if (cur_mode == MODE_KEEP_FIRST) return 0;
        return (cur_mode == MODE_QUIETEST) ? 2 : 1;
    endfunction

    function automatic int unsigned eff_count(int unsigned m);
        int unsigned n;
        n = (cur_group > GMAX) ? GMAX : cur_group;
        if (m != 0 && n == 0) n = 1;
        return n;
    endfunction

    function automatic void restart_group();
        grp_pos = 0;
        best_level = 0;
        best_idx = 0;
        set_start(0, wp);
    endfunction

    function automatic bit close_group(int unsigned m, int unsigned done, int unsigned endpos);
        bit ov;
        set_start(done, endpos);
        if (m == 1) begin
            ov = add_span(start_at(best_idx), start_at(best_idx + 1));
        end
        else begin
            ov = add_span(start_at(0), start_at(best_idx));
            ov = add_span(start_at(best_idx + 1), start_at(done)) || ov;
        end
        return ov;
    endfunction

    function automatic bit close_cycle(int unsigned m, int unsigned n);
        bit ov;
        int unsigned c;
        ov = 1'b0;
        c = grp_pos;
        if (m == 0) begin
            if (c == 0) ov = add_span(start_at(0), wp);
            c++;
            if (c >= n + 1) restart_group();
            else grp_pos = c;
        end
        else begin
            if (m == 1) begin
                if (level > best_level) begin
                    best_level = level;
                    best_idx = c;
                end
            end
            else if (c == 0 || level < best_level) begin
                best_level = level;
                best_idx = c;
            end
            set_start(c + 1, wp);
            c++;
            if (c >= n) begin
                ov = close_group(m, c, wp);
                restart_group();
            end
            else begin
                grp_pos = c;
            end
        end
        level = 0;
        second_half = 0;
        return ov;
    endfunction

    function automatic pull_result_t predict(logic kind, logic [15:0] raw, logic eos);
        pull_result_t r;
        int unsigned m, n, mag, oldest, used;
        int s;
        bit first_ok, second_ok, ov;
        r = '0;
        ov = 1'b0;
        if (kind == REQ_PUSH) begin
            if (!ended) begin
                m = eff_mode();
                n = eff_count(m);
                s = $signed(raw);
                first_ok  = cur_startpos ? (s >= 0) : (s <= 0);
                second_ok = cur_startpos ? (s <= 0) : (s >= 0);
                if (second_half && !second_ok) ov = close_cycle(m, n);
                else if (!second_half && !first_ok) second_half = 1;
                mag = (s < 0) ? -s : s;
                level = (level > LEVEL_MAX - mag) ? LEVEL_MAX : level + mag;
                if (m != 0 || grp_pos == 0) begin
                    oldest = span_n ? rp % DEPTH : start_at(0);
                    used = (wp + DEPTH - oldest) % DEPTH;
                    if (used >= DEPTH - 1) begin
                        ov = 1'b1;
                    end
                    else begin
                        ring[wp % DEPTH] = raw;
                        wp = (wp + 1) % DEPTH;
                    end
                end
                if (eos) begin
                    if (m == 0) begin
                        if (grp_pos == 0) ov = add_span(start_at(0), wp) || ov;
                    end
                    else if (grp_pos > 0) begin
                        ov = close_group(m, grp_pos, wp) || ov;
                    end
                    ended = 1;
                end
            end
        end
        else if (span_n > 0) begin
            r.smp = ring[rp % DEPTH];
            r.vld = 1'b1;
            rp = (rp + 1) % DEPTH;
            if (rp == span_hi[0]) begin
                for (int k = 1; k < span_n; k++) begin
                    span_lo[k-1] = span_lo[k];
                    span_hi[k-1] = span_hi[k];
                end
                span_n--;
                if (span_n) rp = span_lo[0];
            end
            r.lst = (ended && span_n == 0);
        end
        r.ovf = ov;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // send one request transaction
    task automatic send_request(logic kind, logic [15:0] smp, logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid = 1'b0;
            @(negedge clk);
        end
        req_bus.valid = 1'b1;
        req_bus.req_type = kind;
        req_bus.sample = smp;
        req_bus.end_of_stream = eos;
        do @(posedge clk); while (!req_bus.ready);
        expected_results.push_back(predict(kind, smp, eos));
        @(negedge clk);
        req_bus.valid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data = val;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            REG_MODE:      cur_mode = val & 3;
            REG_GROUP:     cur_group = val;
            REG_START_POS: cur_startpos = val & 1;
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    function automatic logic [15:0] wave_sample();
        int mag;
        int pick;
        pick = $urandom_range(99);
        if (pick < 6) return 16'($urandom());
        if (half_left == 0) begin
            half_left = $urandom_range(1, 6);
            half_neg = ~half_neg;
        end
        half_left--;
        if (pick < 10) return 16'sd0;
        if (pick < 14) return half_neg ? 16'h8000 : 16'h7fff;
        mag = $urandom_range(1, 32767);
        if (pick < 40) mag = $urandom_range(1, 300);
        return half_neg ? 16'(-mag) : 16'(mag);
    endfunction

    task automatic push_wave();
        send_request(REQ_PUSH, wave_sample(), 1'b0);
    endtask

    task automatic pull_one();
        send_request(REQ_PULL, 16'($urandom()), 1'($urandom_range(1)));
    endtask

    // bring the block to a group boundary with nothing queued, then let it go quiet
    task automatic settle();
        while (grp_pos != 0) push_wave();
        while (span_n != 0) pull_one();
        while (expected_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic configure(int unsigned m, int unsigned n, int unsigned sp);
        settle();
        write_reg(REG_MODE, CFG_DATA_W'(m));
        write_reg(REG_GROUP, CFG_DATA_W'(n));
        write_reg(REG_START_POS, CFG_DATA_W'(sp));
    endtask

    task automatic run_traffic(int count, int pull_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < pull_pct) pull_one();
            else push_wave();
        end
    endtask

    task automatic test_directed();
        logic [15:0] pattern [] = '{16'h7fff, 16'h0000, 16'h8000, 16'hffff, 16'h0001,
                                    16'hfffb, 16'h0007, 16'h0000, 16'hfffe, 16'h0003,
                                    16'h0004, 16'hfff0};
        foreach (pattern[i]) send_request(REQ_PUSH, pattern[i], 1'b0);
        repeat (6) pull_one();
        configure(MODE_QUIETEST, 3, 0);
        foreach (pattern[i]) send_request(REQ_PUSH, pattern[i], 1'b0);
        repeat (4) pull_one();
    endtask

    task automatic test_modes();
        configure(MODE_KEEP_FIRST, 2, 1);
        run_traffic(50, 45);
        configure(MODE_KEEP_FIRST, 0, 0);
        run_traffic(35, 50);
        configure(MODE_LOUDEST, 1, 1);
        run_traffic(35, 50);
        configure(MODE_QUIETEST, 16, 1);
        run_traffic(50, 40);
        configure(2'd3, 31, 0);
        run_traffic(35, 45);
        configure(MODE_QUIETEST, 0, 1);
        run_traffic(35, 50);
        configure(MODE_KEEP_FIRST, 20, 0);
        run_traffic(40, 45);
    endtask

    // every cycle kept and nothing pulled: the range queue fills and further ranges are lost
    task automatic test_queue_full();
        configure(MODE_LOUDEST, 1, 1);
        repeat (80) push_wave();
        while (span_n != 0) pull_one();
    endtask

    task automatic test_end_of_stream();
        configure(MODE_QUIETEST, 4, 1);
        run_traffic(60, 40);
        send_request(REQ_PUSH, wave_sample(), 1'b1);
        while (span_n != 0) pull_one();
        send_request(REQ_PUSH, 16'h1234, 1'b1);
        send_request(REQ_PUSH, 16'h8001, 1'b0);
        repeat (3) pull_one();
    endtask

    always @(negedge clk) res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk) begin
        pull_result_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("wavecycle_group_deleter verification failed");
            $finish;
        end
        if (res_bus.valid && res_bus.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end
            else begin
                want = expected_results.pop_front();
                if (res_bus.out_sample !== want.smp)
                    report_mismatch("out_sample", $signed(res_bus.out_sample), $signed(want.smp));
                if (res_bus.out_valid !== want.vld)
                    report_mismatch("out_valid", res_bus.out_valid, want.vld);
                if (res_bus.out_last !== want.lst)
                    report_mismatch("out_last", res_bus.out_last, want.lst);
                if (res_bus.overflow !== want.ovf)
                    report_mismatch("overflow", res_bus.overflow, want.ovf);
            end
        end
    end

    initial begin
        req_bus.valid = 1'b0;
        req_bus.req_type = REQ_PUSH;
        req_bus.sample = '0;
        req_bus.end_of_stream = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_MODE;
        cfg_bus.data = '0;
        res_bus.ready = 1'b0;
        foreach (ring[i]) ring[i] = '0;
        foreach (starts[i]) starts[i] = 0;
        level = 0; best_level = 0; best_idx = 0; grp_pos = 0; second_half = 0;
        wp = 0; rp = 0; span_n = 0; ended = 0;
        cur_mode = MODE_LOUDEST; cur_group = 2; cur_startpos = 1;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        send_idle_pct = 38; recv_stall_pct = 68;
        test_modes();
        send_idle_pct = 68; recv_stall_pct = 38;
        test_modes();
        send_idle_pct = 0; recv_stall_pct = 0;
        test_queue_full();
        test_end_of_stream();

        while (expected_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("wavecycle_group_deleter verification clean");
        else
            $display("wavecycle_group_deleter verification failed");
        $finish;
    end

endmodule
